// ===== rtl/spbg_pkg.sv =====
package spbg_pkg;

   // Sample width as the detector sees it and width of all internal counters.
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 32;

   // Widths of the external fields.
   localparam int THRESH_BITS = 16;
   localparam int INDEX_BITS  = 32;
   localparam int OUT_BITS    = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   // Common width for comparing a sample index against the window bounds.
   localparam int WIDE_BITS = (COUNT_BITS > INDEX_BITS) ? COUNT_BITS : INDEX_BITS;
   // Common width for comparing a sample against the threshold.
   localparam int LEVEL_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Register reset values: 70 mV in Q10.6, window from index 1 to the largest index.
   localparam logic signed [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(70 * 64);
   localparam logic [INDEX_BITS-1:0] FIRST_RESET = INDEX_BITS'(1);
   localparam logic [INDEX_BITS-1:0] LAST_RESET  = {INDEX_BITS{1'b1}};

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_THRESHOLD   = 2'd0,
      CSR_FIRST_INDEX = 2'd1,
      CSR_LAST_INDEX  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic {
      PEAK_SPIKE  = 1'b0,
      PEAK_MISSED = 1'b1
   } peak_kind_type;

   typedef struct packed {
      logic signed [THRESH_BITS-1:0] threshold;
      logic [INDEX_BITS-1:0]         first_index;
      logic [INDEX_BITS-1:0]         last_index;
   } cfg_type;

   // Verdict of the window compare for the sample in the middle of the window.
   typedef struct packed {
      logic                  spike;
      logic                  missed;
      logic [OUT_BITS-1:0]   index;
   } peak_type;

   typedef struct packed {
      peak_kind_type         peak_kind;
      logic [OUT_BITS-1:0]   peak_index;
      logic [OUT_BITS-1:0]   spike_number;
      logic [OUT_BITS-1:0]   missed_number;
      logic [OUT_BITS-1:0]   group_number;
      logic [OUT_BITS-1:0]   group_spikes;
      logic                  group_closed;
   } result_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

endpackage

// ===== rtl/spike_peak_burst_grouper.sv =====
// Spike peak detector and burst grouper. Each sample transaction on the req_ channel
// (signed Q10.6 millivolts) is compared with the two samples before it, and the middle
// sample is judged: a strict local maximum whose index lies in [first_index, last_index]
// yields one rsp_ transaction, a spike when above the threshold or a missed peak when
// below it; a maximum equal to the threshold yields nothing. Spikes are counted into the
// current group, and a missed peak following a spike closes that group (group_closed)
// and advances the group number. All counters saturate at all ones. The first sample is
// index 0 and is never judged, and the result for the sample at index n appears after
// sample n+1 is taken. Throughput is one sample per clock while req_stall is low: the
// window compare and the counter update finish in the same cycle as the transaction is
// accepted, and the result is registered in a two-entry output queue (output register
// plus skid register) that decouples the sides; req_stall is raised only while both
// entries hold results. Registers are written through the csr_ port, by the user only
// while the block is idle (unenforced); csr_ready is always high; index 3 is ignored.
module spike_peak_burst_grouper (
   input  logic                                  clock,
   input  logic                                  reset,
   // Sample input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [15:0]                    req_sample,
   // Peak results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [0:0]                            rsp_peak_kind,
   output logic [31:0]                           rsp_peak_index,
   output logic [31:0]                           rsp_spike_number,
   output logic [31:0]                           rsp_missed_number,
   output logic [31:0]                           rsp_group_number,
   output logic [31:0]                           rsp_group_spikes,
   output logic [0:0]                            rsp_group_closed,
   // Register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [spbg_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [spbg_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import spbg_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic [SAMPLE_BITS-1:0] sample;
   peak_type   peak;
   logic       res_valid;
   result_type res;
   result_type rsp;

   // Register file. Writes are only expected while no transaction is in flight.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD:   cfg_in.threshold   = THRESH_BITS'(csr_data);
            CSR_FIRST_INDEX: cfg_in.first_index = INDEX_BITS'(csr_data);
            CSR_LAST_INDEX:  cfg_in.last_index  = INDEX_BITS'(csr_data);
            CSR_UNUSED:      cfg_in = cfg_ff;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= THRESH_RESET;
         cfg_ff.first_index <= FIRST_RESET;
         cfg_ff.last_index  <= LAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // A sample is taken whenever the output queue has a free skid entry.
   assign accept = req_valid && !req_stall;
   assign sample = SAMPLE_BITS'($unsigned(req_sample));

   spbg_judge u_judge (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (sample),
      .cfg    (cfg_ff),
      .peak   (peak)
   );

   spbg_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .peak      (peak),
      .res_valid (res_valid),
      .res       (res)
   );

   spbg_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp),
      .out_stall (rsp_stall)
   );

   assign rsp_peak_kind     = rsp.peak_kind;
   assign rsp_peak_index    = rsp.peak_index;
   assign rsp_spike_number  = rsp.spike_number;
   assign rsp_missed_number = rsp.missed_number;
   assign rsp_group_number  = rsp.group_number;
   assign rsp_group_spikes  = rsp.group_spikes;
   assign rsp_group_closed  = rsp.group_closed;

endmodule

// ===== rtl/spbg_judge.sv =====
module spbg_judge (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [spbg_pkg::SAMPLE_BITS-1:0]       sample,
   input  spbg_pkg::cfg_type                      cfg,
   output spbg_pkg::peak_type                     peak
);
   import spbg_pkg::*;

   logic signed [SAMPLE_BITS-1:0] older_ff, older_in;
   logic signed [SAMPLE_BITS-1:0] middle_ff, middle_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;

   logic signed [SAMPLE_BITS-1:0] cur;
   logic [COUNT_BITS-1:0]         centre;
   logic [WIDE_BITS-1:0]          centre_w;
   logic                          armed;
   logic                          is_max;
   logic                          in_window;
   logic signed [LEVEL_BITS-1:0]  level;
   logic signed [LEVEL_BITS-1:0]  thresh;

   assign cur       = sample;
   assign centre    = count_ff - COUNT_BITS'(1);
   assign centre_w  = WIDE_BITS'(centre);
   // A window exists once two samples are stored; a saturated count stops judging.
   assign armed     = (count_ff >= COUNT_BITS'(2)) && (count_ff != COUNT_MAX);
   assign is_max    = (middle_ff > older_ff) && (middle_ff > cur);
   assign in_window = (centre_w >= WIDE_BITS'(cfg.first_index)) &&
                      (centre_w <= WIDE_BITS'(cfg.last_index));
   assign level     = LEVEL_BITS'(middle_ff);
   assign thresh    = LEVEL_BITS'(cfg.threshold);

   always_comb begin
      peak.spike  = armed && is_max && in_window && (level > thresh);
      peak.missed = armed && is_max && in_window && (level < thresh);
      peak.index  = OUT_BITS'(centre);
   end

   always_comb begin
      older_in  = older_ff;
      middle_in = middle_ff;
      count_in  = count_ff;
      if (accept) begin
         older_in  = middle_ff;
         middle_in = cur;
         count_in  = sat_inc(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff  <= '0;
         middle_ff <= '0;
         count_ff  <= '0;
      end else begin
         older_ff  <= older_in;
         middle_ff <= middle_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/spbg_tally.sv =====
module spbg_tally (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  spbg_pkg::peak_type   peak,
   output logic                 res_valid,
   output spbg_pkg::result_type res
);
   import spbg_pkg::*;

   logic [COUNT_BITS-1:0] spike_total_ff, spike_total_in;
   logic [COUNT_BITS-1:0] missed_total_ff, missed_total_in;
   logic [COUNT_BITS-1:0] group_index_ff, group_index_in;
   logic [COUNT_BITS-1:0] group_spikes_ff, group_spikes_in;
   logic                  last_spike_ff, last_spike_in;
   logic [COUNT_BITS-1:0] reported_spikes;
   logic                  closing;

   always_comb begin
      spike_total_in  = spike_total_ff;
      missed_total_in = missed_total_ff;
      group_index_in  = group_index_ff;
      group_spikes_in = group_spikes_ff;
      last_spike_in   = last_spike_ff;
      reported_spikes = group_spikes_ff;
      closing         = 1'b0;
      if (accept && peak.spike) begin
         spike_total_in  = sat_inc(spike_total_ff);
         group_spikes_in = sat_inc(group_spikes_ff);
         reported_spikes = group_spikes_in;
         last_spike_in   = 1'b1;
      end else if (accept && peak.missed) begin
         missed_total_in = sat_inc(missed_total_ff);
         // A missed peak right after a spike ends the current group.
         if (last_spike_ff) begin
            group_index_in  = sat_inc(group_index_ff);
            group_spikes_in = '0;
            closing         = 1'b1;
         end
         last_spike_in = 1'b0;
      end
   end

   always_comb begin
      res_valid         = accept && (peak.spike || peak.missed);
      res.peak_kind     = peak.missed ? PEAK_MISSED : PEAK_SPIKE;
      res.peak_index    = peak.index;
      res.spike_number  = OUT_BITS'(spike_total_in);
      res.missed_number = OUT_BITS'(missed_total_in);
      res.group_number  = OUT_BITS'(group_index_in);
      res.group_spikes  = OUT_BITS'(reported_spikes);
      res.group_closed  = closing;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spike_total_ff  <= '0;
         missed_total_ff <= '0;
         group_index_ff  <= '0;
         group_spikes_ff <= '0;
         last_spike_ff   <= 1'b0;
      end else begin
         spike_total_ff  <= spike_total_in;
         missed_total_ff <= missed_total_in;
         group_index_ff  <= group_index_in;
         group_spikes_ff <= group_spikes_in;
         last_spike_ff   <= last_spike_in;
      end
   end

   a_closed_is_missed: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.group_closed |-> res.peak_kind == PEAK_MISSED)
      else $error("group closed by a spike");

   a_close_clears_group: assert property (@(posedge clock) disable iff (reset)
      accept && peak.missed && !peak.spike && last_spike_ff |=> group_spikes_ff == '0)
      else $error("group spike count not cleared on close");

   a_spike_marks_last: assert property (@(posedge clock) disable iff (reset)
      accept && peak.spike |=> last_spike_ff && spike_total_ff != '0)
      else $error("spike not recorded");

endmodule

// ===== rtl/spbg_outq.sv =====
module spbg_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  spbg_pkg::result_type in_data,
   output logic                 in_stall,
   output logic                 out_valid,
   output spbg_pkg::result_type out_data,
   input  logic                 out_stall
);
   import spbg_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_stall && skid_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved forward");

   a_skid_fills: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stall && in_valid && !skid_valid_ff |=> skid_valid_ff)
      else $error("result lost while output stalled");

endmodule

// ===== test/spike_peak_burst_grouper_test.sv =====
module spike_peak_burst_grouper_test;
   import spbg_pkg::*;

   // The ledger follows the detector one sample at a time. Every accepted sample
   // transaction is judged here exactly as the block should judge it, and any peak it
   // reports is queued until the matching rsp_ transaction shows up.
   class peak_ledger;
      logic signed [15:0] threshold;
      logic [31:0]        first_idx;
      logic [31:0]        last_idx;
      logic signed [15:0] older;
      logic signed [15:0] middle;
      logic [31:0]        seen_samples;
      logic [31:0]        spike_total;
      logic [31:0]        missed_total;
      logic [31:0]        group_idx;
      logic [31:0]        group_size;
      logic               last_spike;
      result_type         pending_peaks[$];
      int                 faults;

      function new();
         threshold    = THRESH_RESET;
         first_idx    = FIRST_RESET;
         last_idx     = LAST_RESET;
         older        = '0;
         middle       = '0;
         seen_samples = '0;
         spike_total  = '0;
         missed_total = '0;
         group_idx    = '0;
         group_size   = '0;
         last_spike   = 1'b0;
         faults       = 0;
      endfunction

      function logic [31:0] bump(logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] d);
         case (idx)
            CSR_THRESHOLD:   threshold = d[15:0];
            CSR_FIRST_INDEX: first_idx = d;
            CSR_LAST_INDEX:  last_idx  = d;
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [15:0] cur);
         result_type  r;
         logic [31:0] centre;
         logic        hit;
         r   = '0;
         hit = 1'b0;
         if (seen_samples >= 32'd2 && seen_samples != 32'hFFFF_FFFF) begin
            centre = seen_samples - 32'd1;
            if (middle > older && middle > cur && centre >= first_idx && centre <= last_idx) begin
               if (middle > threshold) begin
                  spike_total    = bump(spike_total);
                  group_size     = bump(group_size);
                  last_spike     = 1'b1;
                  r.peak_kind    = PEAK_SPIKE;
                  r.group_spikes = group_size;
                  hit            = 1'b1;
               end else if (middle < threshold) begin
                  missed_total   = bump(missed_total);
                  r.peak_kind    = PEAK_MISSED;
                  r.group_spikes = group_size;
                  if (last_spike) begin
                     group_idx      = bump(group_idx);
                     group_size     = '0;
                     r.group_closed = 1'b1;
                  end
                  last_spike = 1'b0;
                  hit        = 1'b1;
               end
               if (hit) begin
                  r.peak_index    = centre;
                  r.spike_number  = spike_total;
                  r.missed_number = missed_total;
                  r.group_number  = group_idx;
                  pending_peaks.push_back(r);
               end
            end
         end
         older        = middle;
         middle       = cur;
         seen_samples = bump(seen_samples);
      endfunction

      function void check_peak(result_type got);
         result_type want;
         if (pending_peaks.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected peak result: index %0d kind %0d", got.peak_index,
                        got.peak_kind);
            return;
         end
         want = pending_peaks.pop_front();
         if (got.peak_kind != want.peak_kind || got.peak_index != want.peak_index ||
             got.spike_number != want.spike_number ||
             got.missed_number != want.missed_number ||
             got.group_number != want.group_number ||
             got.group_spikes != want.group_spikes ||
             got.group_closed != want.group_closed) begin
            faults++;
            if (faults <= 10) begin
               $display("peak mismatch, expected: kind %0d index %0d spikes %0d missed %0d group %0d in_group %0d closed %0d",
                        want.peak_kind, want.peak_index, want.spike_number,
                        want.missed_number, want.group_number, want.group_spikes,
                        want.group_closed);
               $display("                 actual: kind %0d index %0d spikes %0d missed %0d group %0d in_group %0d closed %0d",
                        got.peak_kind, got.peak_index, got.spike_number,
                        got.missed_number, got.group_number, got.group_spikes,
                        got.group_closed);
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [15:0]        req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [0:0]                rsp_peak_kind;
   logic [31:0]               rsp_peak_index;
   logic [31:0]               rsp_spike_number;
   logic [31:0]               rsp_missed_number;
   logic [31:0]               rsp_group_number;
   logic [31:0]               rsp_group_spikes;
   logic [0:0]                rsp_group_closed;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index = CSR_THRESHOLD;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   peak_ledger ledger = new();

   // Idling controls, in percent of cycles, set per phase by the stimulus process.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // Cycles left in a forced receiver hold-off; counted down by the receiver process.
   int hold_left = 0;
   // Previous generated sample, used to build plateaus.
   logic signed [15:0] last_pick = '0;

   spike_peak_burst_grouper dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_peak_kind(rsp_peak_kind),
      .rsp_peak_index(rsp_peak_index),
      .rsp_spike_number(rsp_spike_number),
      .rsp_missed_number(rsp_missed_number),
      .rsp_group_number(rsp_group_number),
      .rsp_group_spikes(rsp_group_spikes),
      .rsp_group_closed(rsp_group_closed),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Receiver side. A forced hold-off takes priority over random stalling, so the
   // block's two-entry output queue fills and it must push back on its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Both channels are observed at the clock edge, where every signal still carries the
   // value the block sampled. A result transaction is checked before the sample accepted
   // at the same edge is judged; the two never relate to each other anyway.
   always @(posedge clock) begin : watch
      result_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.peak_kind     = peak_kind_type'(rsp_peak_kind);
            seen.peak_index    = rsp_peak_index;
            seen.spike_number  = rsp_spike_number;
            seen.missed_number = rsp_missed_number;
            seen.group_number  = rsp_group_number;
            seen.group_spikes  = rsp_group_spikes;
            seen.group_closed  = rsp_group_closed;
            ledger.check_peak(seen);
         end
         if (req_valid && !req_stall)
            ledger.note_sample(req_sample);
      end
   end

   // Offers one sample transaction and returns at the edge where it is taken. Valid is
   // left high so that back-to-back samples never lower and raise it in one step.
   task automatic send_sample(input logic signed [15:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // One register write transaction; csr_valid stays high for a following write.
   task automatic csr_write(input csr_index_type idx, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      ledger.set_register(idx, d);
   endtask

   // Rewrites all three registers. The upper half of the threshold word carries random
   // bits, which the block must ignore. Optionally a write to the unused index follows.
   task automatic program_window(input logic signed [15:0] thr, input logic [31:0] first,
                                 input logic [31:0] last, input bit poke_unused);
      csr_write(CSR_THRESHOLD, {16'($urandom), thr});
      csr_write(CSR_FIRST_INDEX, first);
      csr_write(CSR_LAST_INDEX, last);
      if (poke_unused)
         csr_write(CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits, with a bound, until every queued peak has arrived, then lets the clock run on
   // so that the block can finish any sample that produces nothing.
   task automatic drain();
      int waited;
      waited = 0;
      @(posedge clock);
      while (ledger.pending_peaks.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Random samples: mostly full-range values, with plateaus, values at and around the
   // threshold and the two rail values mixed in so that every special case recurs.
   function automatic logic signed [15:0] pick_sample();
      int roll;
      logic signed [15:0] s;
      roll = $urandom_range(99);
      if (roll < 8)
         s = last_pick;
      else if (roll < 16)
         s = ledger.threshold;
      else if (roll < 30)
         s = ledger.threshold + 16'($urandom_range(400)) - 16'sd200;
      else if (roll < 35)
         s = 16'sh7FFF;
      else if (roll < 40)
         s = 16'sh8000;
      else
         s = 16'($urandom);
      last_pick = s;
      return s;
   endfunction

   task automatic run_phase(input int items, input int send_pct, input int stall_pct,
                            input int hold);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      hold_left      = hold;
      repeat (items)
         send_sample(pick_sample());
      req_valid <= 1'b0;
      drain();
   endtask

   // Directed opening: a rail-to-rail spike, a peak exactly at threshold, a plateau, a
   // group of three spikes closed by a missed peak, a missed peak closing nothing, and
   // peaks one step either side of the threshold.
   logic signed [15:0] lead_in [23] = '{
      -16'sd32768, 16'sd32767, -16'sd32768, 16'sd4480, 16'sd0, 16'sd300, 16'sd300,
      16'sd100, 16'sd5000, 16'sd0, 16'sd6000, 16'sd1, 16'sd1000, -16'sd5, 16'sd2000,
      -16'sd3, 16'sd32767, -16'sd32768, 16'sd4481, -16'sd32768, 16'sd4479, -16'sd32768,
      16'sd0
   };

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A window opening at index 0 must still never judge the very first sample.
      program_window(THRESH_RESET, 32'd0, LAST_RESET, 1'b0);
      foreach (lead_in[i])
         send_sample(lead_in[i]);
      req_valid <= 1'b0;
      drain();

      // Power-on settings, no idling on either side.
      program_window(THRESH_RESET, FIRST_RESET, LAST_RESET, 1'b0);
      run_phase(150, 0, 0, 0);

      // Lowest threshold: every reported peak is a spike. Sender idles often.
      program_window(-16'sd32768, 32'd1, 32'hFFFF_FFFF, 1'b0);
      run_phase(120, 69, 0, 0);

      // Highest threshold: only missed peaks, or nothing at the rail. Receiver stalls.
      program_window(16'sd32767, 32'd1, 32'hFFFF_FFFF, 1'b0);
      run_phase(100, 0, 69, 0);

      // Narrow window a little ahead of the current index, both sides idling.
      program_window(16'($urandom), ledger.seen_samples + 32'd20,
                     ledger.seen_samples + 32'd80, 1'b0);
      run_phase(150, 26, 26, 0);

      // Empty window (first above last), plus a write to the unused register index.
      program_window(16'($urandom), ledger.seen_samples + 32'd50,
                     ledger.seen_samples + 32'd10, 1'b1);
      run_phase(60, 69, 69, 0);

      // Window pinned to the largest index: nothing reachable is reported.
      program_window(16'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      run_phase(40, 0, 0, 0);

      // Long receiver hold-off while the sender keeps offering, so input backs up.
      program_window(16'sd0, 32'd1, 32'hFFFF_FFFF, 1'b0);
      run_phase(150, 0, 0, 60);

      // Random threshold, both sides idling.
      program_window(16'($urandom), 32'd1, 32'hFFFF_FFFF, 1'b0);
      run_phase(200, 26, 26, 0);

      // Anything still queued never arrived.
      ledger.faults += ledger.pending_peaks.size();
      if (ledger.faults == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== spike_peak_burst_grouper.f =====
rtl/spbg_pkg.sv
rtl/spbg_judge.sv
rtl/spbg_tally.sv
rtl/spbg_outq.sv
rtl/spike_peak_burst_grouper.sv
test/spike_peak_burst_grouper_test.sv
